### hw/rtl/assert_macros.svh
// Assertion helpers; every user must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Condition must never hold.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### hw/rtl/srrip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srrip_pkg;

	localparam int ADDR_W = 32;
	localparam int CNT_W  = 32;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic             way;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
	} rsp_t;

endpackage

`default_nettype wire

### hw/rtl/srrip_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srrip_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/srrip_set_assoc_cache_core.sv
// Set-associative cache tag array with SRRIP replacement.
// req (sink): one byte address per transfer. rsp (source): one result per
// request, carrying hit, the low bit of the hit/filled way, and the running
// hit and miss totals including this access (both wrap at 2^32).
// Each set is one row of a single synchronous RAM: tags, valid bits and
// re-reference values of all ways. A request reads its row on the accept
// edge; the lookup state that follows matches, ages, picks the victim and,
// once the output register is free, writes the row back and loads the result.
// The block takes a new request only after the previous one has written its
// row back, so back-to-back accesses to the same set always see updated state.
// Reset: all control state clears, then a clearing pass writes every row
// to invalid with maximum re-reference values; req.ready stays low during
// the pass.
// Stall: a result waiting in the output register does not block the next
// request transfer; that request's lookup holds until rsp is taken.
// NUM_SETS and BLOCK_BYTES must be powers of two.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module srrip_set_assoc_cache_core
	import srrip_pkg::*;
#(
	parameter int NUM_SETS    = 256,
	parameter int WAYS        = 2,
	parameter int BLOCK_BYTES = 64,
	parameter int RRPV_BITS   = 2
) (
	input wire logic        clk,
	input wire logic        arst_n,
	srrip_stream_if.sink    req,
	srrip_stream_if.source  rsp
);

	localparam int OFF_W    = $clog2(BLOCK_BYTES);
	localparam int SET_BITS = $clog2(NUM_SETS);
	localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W    = WAYS * (TAG_W + 1 + RRPV_BITS);
	localparam logic [RRPV_BITS-1:0] RRPV_SAT = RRPV_BITS'((1 << RRPV_BITS) - 1);
	localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NUM_SETS - 1);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_LOOKUP = 1'b1;

	logic                           state_q;
	logic                           clr_busy_q;
	logic [IDX_W-1:0]               clr_idx_q;
	logic [IDX_W-1:0]               idx_s1;
	logic [TAG_W-1:0]               tag_s1;
	logic [CNT_W-1:0]               hit_cnt_q;
	logic [CNT_W-1:0]               miss_cnt_q;
	logic [CNT_W-1:0]               total_cnt;
	logic                           rsp_valid_q;
	rsp_t                           rsp_q;

	logic                           accept;
	logic                           done;
	logic [ADDR_W-1:0]              addr_sh;
	logic [IDX_W-1:0]               req_idx;

	logic                           ram_we;
	logic                           ram_re;
	logic [IDX_W-1:0]               ram_waddr;
	logic [ROW_W-1:0]               ram_wdata;
	logic [ROW_W-1:0]               ram_rdata;
	logic [ROW_W-1:0]               clear_row;
	logic [ROW_W-1:0]               upd_row;

	logic [WAYS-1:0][TAG_W-1:0]     row_tags;
	logic [WAYS-1:0]                row_valids;
	logic [WAYS-1:0][RRPV_BITS-1:0] row_rrpvs;
	logic [WAYS-1:0][TAG_W-1:0]     new_tags;
	logic [WAYS-1:0]                new_valids;
	logic [WAYS-1:0][RRPV_BITS-1:0] new_rrpvs;
	logic                           lk_hit;
	logic [WAY_W-1:0]               lk_way;

	// ---- request side ----
	assign req.ready = (state_q == ST_IDLE) && !clr_busy_q;
	assign accept    = req.valid && req.ready;
	// lookup finishes once the output register is free or being emptied
	assign done      = (state_q == ST_LOOKUP) && (!rsp_valid_q || rsp.ready);

	assign addr_sh = req.data.address >> OFF_W;
	assign req_idx = IDX_W'(addr_sh & ADDR_W'(NUM_SETS - 1));

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= req_idx;
			tag_s1 <= TAG_W'(req.data.address >> (OFF_W + SET_BITS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- clearing pass after reset ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---- set RAM: row = {tags, valids, rrpvs} ----
	assign clear_row = {{(WAYS * TAG_W){1'b0}}, {WAYS{1'b0}}, {WAYS{RRPV_SAT}}};
	assign upd_row   = {new_tags, new_valids, new_rrpvs};

	assign ram_re    = accept;
	assign ram_we    = clr_busy_q || done;
	assign ram_waddr = clr_busy_q ? clr_idx_q : idx_s1;
	assign ram_wdata = clr_busy_q ? clear_row : upd_row;

	srrip_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_set_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (req_idx),
		.rdata (ram_rdata)
	);

	// read data holds while the lookup waits on the output
	assign {row_tags, row_valids, row_rrpvs} = ram_rdata;

	srrip_lookup #(
		.WAYS      (WAYS),
		.TAG_W     (TAG_W),
		.RRPV_BITS (RRPV_BITS)
	) u_lookup (
		.tags       (row_tags),
		.valids     (row_valids),
		.rrpvs      (row_rrpvs),
		.tag        (tag_s1),
		.hit        (lk_hit),
		.way        (lk_way),
		.new_tags   (new_tags),
		.new_valids (new_valids),
		.new_rrpvs  (new_rrpvs)
	);

	// ---- totals ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (done) begin
			if (lk_hit) begin
				hit_cnt_q <= hit_cnt_q + CNT_W'(1);
			end else begin
				miss_cnt_q <= miss_cnt_q + CNT_W'(1);
			end
		end
	end

	assign total_cnt = hit_cnt_q + miss_cnt_q;

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q.hit        <= lk_hit;
			rsp_q.way        <= lk_way[0];
			rsp_q.hit_total  <= lk_hit ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;
			rsp_q.miss_total <= lk_hit ? miss_cnt_q : miss_cnt_q + CNT_W'(1);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// ---- checks ----
	`ASSERT_NEVER(a_ram_port_clash, ram_re && ram_we, "set RAM read and written in one cycle")
	`ASSERT_IMPLIES(a_no_req_in_clear, clr_busy_q, !req.ready, "request taken during clearing pass")
	`ASSERT_NEXT(a_one_count, done, total_cnt == $past(total_cnt) + CNT_W'(1), "lookup counted wrong")
	`ASSERT_NEXT(a_result_loaded, done, rsp.valid, "finished lookup left no result")

endmodule

`default_nettype wire

### hw/rtl/srrip_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module srrip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/srrip_lookup.sv
`timescale 1ns / 1ps
`default_nettype none

// Tag match, SRRIP aging and victim pick for one set row.
module srrip_lookup #(
	parameter int WAYS      = 2,
	parameter int TAG_W     = 18,
	parameter int RRPV_BITS = 2,
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  wire logic [WAYS-1:0][TAG_W-1:0]     tags,
	input  wire logic [WAYS-1:0]                valids,
	input  wire logic [WAYS-1:0][RRPV_BITS-1:0] rrpvs,
	input  wire logic [TAG_W-1:0]               tag,
	output logic                                hit,
	output logic      [WAY_W-1:0]               way,
	output logic      [WAYS-1:0][TAG_W-1:0]     new_tags,
	output logic      [WAYS-1:0]                new_valids,
	output logic      [WAYS-1:0][RRPV_BITS-1:0] new_rrpvs
);

	localparam logic [RRPV_BITS-1:0] RRPV_SAT = RRPV_BITS'((1 << RRPV_BITS) - 1);
	localparam logic [RRPV_BITS-1:0] RRPV_INS = RRPV_BITS'((1 << RRPV_BITS) - 2);

	logic [WAY_W-1:0]               hit_way;
	logic [WAY_W-1:0]               victim;
	logic [RRPV_BITS-1:0]           top;
	logic [RRPV_BITS-1:0]           lift;
	logic [WAYS-1:0][RRPV_BITS-1:0] aged;

	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		// descending so the lowest matching way wins
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valids[w] && (tags[w] == tag)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		top = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (rrpvs[w] > top) begin
				top = rrpvs[w];
			end
		end
		// raise the set just enough that the oldest way reaches the maximum
		lift = RRPV_SAT - top;
		for (int w = 0; w < WAYS; w++) begin
			aged[w] = rrpvs[w] + lift;
		end
		victim = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (aged[w] == RRPV_SAT) begin
				victim = WAY_W'(w);
			end
		end
	end

	always_comb begin
		new_tags   = tags;
		new_valids = valids;
		new_rrpvs  = rrpvs;
		if (hit) begin
			new_rrpvs[hit_way] = '0;
			way                = hit_way;
		end else begin
			new_rrpvs          = aged;
			new_rrpvs[victim]  = RRPV_INS;
			new_tags[victim]   = tag;
			new_valids[victim] = 1'b1;
			way                = victim;
		end
	end

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

// Address-stream check of the SRRIP tag array: a shadow copy of tags, valid bits
// and re-reference values predicts hit, way and both running totals per access.
module tb_top;
	import srrip_pkg::*;

	// Geometry matches the instance parameters below
	localparam int SETS     = 256;
	localparam int NWAYS    = 2;
	localparam int BLK      = 64;
	localparam int RRPV_W   = 2;
	localparam int OFF_W    = $clog2(BLK);
	localparam int IDX_W    = $clog2(SETS);
	localparam int TAG_W    = ADDR_W - OFF_W - IDX_W;
	localparam logic [RRPV_W-1:0] RRPV_SAT = '1;
	localparam logic [RRPV_W-1:0] RRPV_INS = RRPV_SAT - 1'b1;

	localparam int N_RANDOM   = 1000;
	localparam int PHASE_LEN  = 128;   // accepted requests per idling phase
	localparam int STALL_LIMIT = 2000; // cycles with no transfer on either side
	localparam int MAX_LOGGED = 10;
	localparam int DRAIN_CYC  = 10;

	typedef enum logic [1:0] {
		PH_FREE,
		PH_SRC_IDLE,
		PH_SNK_STALL,
		PH_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;

	srrip_stream_if #(.payload_t(req_t)) req ();
	srrip_stream_if #(.payload_t(rsp_t)) rsp ();

	srrip_set_assoc_cache_core #(
		.NUM_SETS   (SETS),
		.WAYS       (NWAYS),
		.BLOCK_BYTES(BLK),
		.RRPV_BITS  (RRPV_W)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Shadow tag array
	logic [TAG_W-1:0]  shadow_tag  [SETS][NWAYS];
	logic              shadow_vld  [SETS][NWAYS];
	logic [RRPV_W-1:0] shadow_rrpv [SETS][NWAYS];
	logic [CNT_W-1:0]  hit_cnt;
	logic [CNT_W-1:0]  miss_cnt;

	req_t addr_q[$];       // requests not yet transferred
	rsp_t lookup_q[$];     // predicted results, oldest first
	int   n_items;
	int   n_req_xfer;
	int   n_rsp_checked;
	int   n_mismatch;
	int   n_aged_fills;
	int   idle_cyc;
	bit   req_xfer;        // request transfer seen at the last rising edge
	idle_mode_t idle_mode;

	always #2 clk = ~clk;

	// Lookup plus SRRIP update on the shadow array; returns the expected result.
	function automatic rsp_t cache_lookup(logic [ADDR_W-1:0] a);
		logic [IDX_W-1:0]  idx;
		logic [TAG_W-1:0]  t;
		logic [RRPV_W-1:0] top;
		logic [RRPV_W-1:0] lift;
		bit                found;
		bit                is_hit;
		int                sel;
		rsp_t              r;
		idx    = a[OFF_W +: IDX_W];
		t      = a[ADDR_W-1 -: TAG_W];
		is_hit = 1'b0;
		sel    = 0;
		for (int w = 0; w < NWAYS; w++) begin
			if (!is_hit && shadow_vld[idx][w] && shadow_tag[idx][w] == t) begin
				is_hit = 1'b1;
				sel    = w;
			end
		end
		if (is_hit) begin
			shadow_rrpv[idx][sel] = '0;
			hit_cnt = hit_cnt + 1'b1;
		end else begin
			miss_cnt = miss_cnt + 1'b1;
			// age the whole set just enough that the oldest way hits the max
			top = '0;
			for (int w = 0; w < NWAYS; w++)
				if (shadow_rrpv[idx][w] > top)
					top = shadow_rrpv[idx][w];
			lift = RRPV_SAT - top;
			if (lift != '0)
				n_aged_fills++;
			for (int w = 0; w < NWAYS; w++)
				shadow_rrpv[idx][w] = shadow_rrpv[idx][w] + lift;
			// victim: lowest way at the max
			found = 1'b0;
			for (int w = 0; w < NWAYS; w++) begin
				if (!found && shadow_rrpv[idx][w] == RRPV_SAT) begin
					found = 1'b1;
					sel   = w;
				end
			end
			shadow_tag[idx][sel]  = t;
			shadow_vld[idx][sel]  = 1'b1;
			shadow_rrpv[idx][sel] = RRPV_INS;
		end
		r.hit        = is_hit;
		r.way        = sel[0];
		r.hit_total  = hit_cnt;
		r.miss_total = miss_cnt;
		return r;
	endfunction

	function automatic req_t mk_req(logic [TAG_W-1:0] t, logic [IDX_W-1:0] idx,
			logic [OFF_W-1:0] off);
		req_t q;
		q.address = {t, idx, off};
		return q;
	endfunction

	// Sample at the rising edge: check results first, then predict new
	// requests, so a result never pairs with a request of the same edge.
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		bit   rsp_xfer;
		rsp_xfer = 1'b0;
		req_xfer = 1'b0;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				rsp_xfer = 1'b1;
				got = rsp.data;
				if (lookup_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= MAX_LOGGED)
						$display("[%0t] unexpected result: hit=%0b way=%0b hits=%0d misses=%0d",
							$time, got.hit, got.way, got.hit_total, got.miss_total);
				end else begin
					want = lookup_q.pop_front();
					n_rsp_checked++;
					if (got.hit !== want.hit || got.way !== want.way ||
						got.hit_total !== want.hit_total ||
						got.miss_total !== want.miss_total) begin
						n_mismatch++;
						if (n_mismatch <= MAX_LOGGED) begin
							$write("[%0t] result %0d: exp hit=%0b way=%0b hits=%0d misses=%0d, ",
								$time, n_rsp_checked, want.hit, want.way, want.hit_total,
								want.miss_total);
							$display("got hit=%0b way=%0b hits=%0d misses=%0d",
								got.hit, got.way, got.hit_total, got.miss_total);
						end
					end
				end
			end
			if (req.valid && req.ready) begin
				req_xfer = 1'b1;
				lookup_q.push_back(cache_lookup(req.data.address));
				n_req_xfer++;
			end
			// watchdog: includes the clearing pass after reset
			if (req_xfer || rsp_xfer)
				idle_cyc = 0;
			else
				idle_cyc++;
			if (idle_cyc >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results pending",
					idle_cyc, lookup_q.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Driver and response stall, both updated at the falling edge
	always @(negedge clk) begin
		int src_pct;
		int snk_pct;
		if (arst_n) begin
			idle_mode = idle_mode_t'((n_req_xfer / PHASE_LEN) % 4);
			src_pct = (idle_mode == PH_SRC_IDLE) ? 53 : (idle_mode == PH_BOTH) ? 34 : 0;
			snk_pct = (idle_mode == PH_SNK_STALL) ? 53 : (idle_mode == PH_BOTH) ? 34 : 0;
			if (req_xfer)
				void'(addr_q.pop_front());
			if (req.valid && !req_xfer) begin
				// hold the current request until it transfers
			end else if (addr_q.size() != 0 && $urandom_range(99) >= src_pct) begin
				req.valid <= 1'b1;
				req.data  <= addr_q[0];
			end else begin
				req.valid <= 1'b0;
			end
			rsp.ready <= ($urandom_range(99) >= snk_pct);
		end
	end

	initial begin
		logic [IDX_W-1:0] hot_set[6];
		logic [TAG_W-1:0] hot_tag[5];
		req_t             last;
		int               roll;
		clk           = 1'b0;
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.data      = '0;
		rsp.ready     = 1'b0;
		n_req_xfer    = 0;
		n_rsp_checked = 0;
		n_mismatch    = 0;
		n_aged_fills  = 0;
		idle_cyc      = 0;
		req_xfer      = 1'b0;
		hit_cnt       = '0;
		miss_cnt      = '0;
		for (int s = 0; s < SETS; s++)
			for (int w = 0; w < NWAYS; w++) begin
				shadow_tag[s][w]  = '0;
				shadow_vld[s][w]  = 1'b0;
				shadow_rrpv[s][w] = RRPV_SAT;
			end

		// Directed: extremes, fill, hit, eviction with and without aging
		addr_q.push_back(mk_req('0, '0, '0));           // cold miss, way 0
		addr_q.push_back(mk_req('0, '0, '1));           // hit, other offset
		addr_q.push_back(mk_req('1, '1, '1));           // all-ones address, miss
		addr_q.push_back(mk_req('1, '1, '0));           // same block, hit
		addr_q.push_back(mk_req(18'd1, '0, 6'd5));      // second way of set 0
		addr_q.push_back(mk_req(18'd2, '0, 6'd9));      // full set, aging, evicts way 1
		addr_q.push_back(mk_req(18'd2, '0, 6'd9));      // hit way 1
		addr_q.push_back(mk_req('0, '0, 6'd3));         // hit way 0
		addr_q.push_back(mk_req(18'd3, '0, '0));        // both at 0: full aging
		addr_q.push_back(mk_req(18'd1, '0, '0));        // miss, evicted earlier
		addr_q.push_back(mk_req(18'd3, '0, '1));        // back-to-back same set
		addr_q.push_back(mk_req(18'd3, '0, '0));
		addr_q.push_back(mk_req(18'h2AAAA, 8'h55, 6'h2A));
		addr_q.push_back(mk_req(18'h15555, 8'hAA, 6'h15));
		addr_q.push_back(mk_req(18'h2AAAA, 8'h55, 6'h15));
		addr_q.push_back(mk_req(18'h15555, 8'h55, 6'h00)); // second way of 0x55
		addr_q.push_back(mk_req(18'h3FFFE, 8'h55, 6'h3F)); // aging eviction
		addr_q.push_back(mk_req('0, '1, '0));           // tag 0 in last set
		addr_q.push_back(mk_req('1, '1, '1));
		addr_q.push_back(mk_req('0, '1, '1));
		addr_q.push_back(mk_req(18'd7, '1, '0));        // replace in last set

		// Random part: mostly a small working set so that hits, aging and eviction
		// keep recurring; some reuse the last block, the rest span the whole space.
		hot_set[0] = '0;
		hot_set[1] = '1;
		for (int i = 2; i < 6; i++)
			hot_set[i] = IDX_W'($urandom());
		hot_tag[0] = '0;
		hot_tag[1] = '1;
		for (int i = 2; i < 5; i++)
			hot_tag[i] = TAG_W'($urandom());
		last = addr_q[$];
		for (int i = 0; i < N_RANDOM; i++) begin
			roll = $urandom_range(99);
			if (roll < 15)
				last.address = ADDR_W'($urandom());
			else if (roll < 30)
				last = mk_req(last.address[ADDR_W-1 -: TAG_W],
					last.address[OFF_W +: IDX_W], OFF_W'($urandom()));
			else
				last = mk_req(hot_tag[$urandom_range(4)], hot_set[$urandom_range(5)],
					OFF_W'($urandom()));
			addr_q.push_back(last);
		end
		n_items = addr_q.size();

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Drain: every request sent and every result checked
		while (n_req_xfer < n_items || lookup_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("%0d accesses checked: %0d hits, %0d misses, %0d fills after aging",
			n_rsp_checked, hit_cnt, miss_cnt, n_aged_fills);
		$display("idling phases cycled every %0d transfers; %0d mismatches",
			PHASE_LEN, n_mismatch);
		if (n_mismatch == 0 && lookup_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/srrip_pkg.sv
hw/rtl/srrip_stream_if.sv
hw/rtl/srrip_ram.sv
hw/rtl/srrip_lookup.sv
hw/rtl/srrip_set_assoc_cache_core.sv
tb/tb_top.sv
